FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the level meter RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/frlm_pkg.sv
// Shared types and constants of the frame RMS level meter.
// No dependencies.
package frlm_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LEVEL_W     = 13;
  localparam int unsigned FLOOR_W     = 15;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned DECAY_W     = 10;
  localparam int unsigned SQ_W        = 31;
  localparam int unsigned MEAN_W      = 31;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned RMS_W       = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 13'd4096;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET   = 15'd115;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 8'd14;
  localparam logic [HOLD_W-1:0]  HOLD_RESET    = 16'd240;
  localparam logic [DECAY_W-1:0] DECAY_RESET   = 10'd737;

  typedef enum logic [1:0] {
    REG_SPEECH_FLOOR = 2'd0,
    REG_LEVEL_GAIN   = 2'd1,
    REG_HOLD_TIME_MS = 2'd2,
    REG_DECAY_FACTOR = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
    logic                       speech_flag;
    logic                       ptt_pressed;
    logic [TIME_W-1:0]          now_ms;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_out;
    logic               talking;
    logic               updated;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIV,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_SUB,
    OP_SCALE,
    OP_DECAY,
    OP_UPDATE,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic in_active;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

FILE: hw/rtl/frlm_in_if.sv
// Sample channel interface: valid, ready and one input item.
// Depends on frlm_pkg.
interface frlm_in_if;
  import frlm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel interface: valid, ready and one result item.
interface frlm_out_if;
  import frlm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/frlm_ctrl.sv
// Controller of the level meter: sequences accumulate, divide, root and level update.
// Depends on frlm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frlm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  frlm_pkg::sts_t  sts,
  output frlm_pkg::cmd_t  cmd
);
  import frlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SQRT_INIT,
    S_SQRT,
    S_SUB,
    S_SCALE,
    S_DECAY,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.accept = (state == S_IDLE) && in_valid;
    unique case (state)
      S_IDLE:      cmd.op = OP_NONE;
      S_DIV:       cmd.op = OP_DIV;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT;
      S_SUB:       cmd.op = OP_SUB;
      S_SCALE:     cmd.op = OP_SCALE;
      S_DECAY:     cmd.op = OP_DECAY;
      S_UPDATE:    cmd.op = OP_UPDATE;
      S_FINISH:    cmd.op = out_free ? OP_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && sts.in_last) begin
            state <= sts.in_active ? S_DIV : S_FINISH;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_SQRT_INIT;
          end
        end
        S_SQRT_INIT: state <= S_SQRT;
        S_SQRT: begin
          if (sts.sqrt_done) begin
            state <= S_SUB;
          end
        end
        S_SUB:    state <= S_SCALE;
        S_SCALE:  state <= S_DECAY;
        S_DECAY:  state <= S_UPDATE;
        S_UPDATE: state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_overwrite, cmd.op == OP_OUT, !out_valid || out_ready)
  `ASSERT_NEXT(a_load_shows, cmd.op == OP_OUT, out_valid)
  `ASSERT_IMPLIES(a_no_accept_busy, cmd.op != OP_NONE, !cmd.accept)

endmodule

FILE: hw/rtl/frlm_dp.sv
// Datapath of the level meter: square accumulator, restoring divider, integer root,
// level scaling with hold and decay, configuration and result registers.
// Depends on frlm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frlm_dp #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  frlm_pkg::cfg_idx_t           cfg_idx,
  input  logic [frlm_pkg::CFG_W-1:0]   cfg_data,
  input  frlm_pkg::in_item_t           in_item,
  input  frlm_pkg::cmd_t               cmd,
  output frlm_pkg::sts_t               sts,
  output frlm_pkg::out_item_t          out_item
);
  import frlm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SUM_W  = CNT_W + 30;
  localparam int unsigned DCNT_W = $clog2(SUM_W);

  // configuration
  logic [FLOOR_W-1:0] speech_floor;
  logic [GAIN_W-1:0]  level_gain;
  logic [HOLD_W-1:0]  hold_time_ms;
  logic [DECAY_W-1:0] decay_factor;

  // persistent state
  logic [SUM_W-1:0]   square_sum;
  logic [CNT_W-1:0]   sample_count;
  logic [LEVEL_W-1:0] held_level;
  logic [TIME_W-1:0]  last_speech_time;

  // working registers
  logic [CNT_W-1:0]   rem;
  logic [DCNT_W-1:0]  div_cnt;
  logic [ROOT_W-1:0]  sq_x;
  logic [ROOT_W-1:0]  sq_res;
  logic [ROOT_W-1:0]  sq_bit;
  logic [RMS_W-1:0]   shifted;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] decayed;
  logic               hold_ok;
  logic               ptt_lat;
  logic [TIME_W-1:0]  now_lat;
  logic               updated;

  logic signed [31:0]       sq_full;
  logic [SUM_W-1:0]         sum_add;
  logic [CNT_W:0]           rem_sh;
  logic                     div_ge;
  logic [CNT_W:0]           rem_sub;
  logic [ROOT_W-1:0]        trial;
  logic [RMS_W-1:0]         rms;
  logic [RMS_W+GAIN_W-1:0]  scale_prod;
  logic [RMS_W+GAIN_W-4:0]  scale_q;
  logic [LEVEL_W+DECAY_W-1:0] decay_prod;
  logic [LEVEL_W-1:0]       prev;
  logic [TIME_W-1:0]        elapsed;
  logic                     in_hold;
  logic                     talk;

  assign sq_full    = 32'(in_item.sample) * 32'(in_item.sample);
  assign sum_add    = square_sum + SUM_W'(sq_full[SQ_W-1:0]);
  assign rem_sh     = {rem, square_sum[SUM_W-1]};
  assign div_ge     = rem_sh >= {1'b0, sample_count};
  assign rem_sub    = rem_sh - {1'b0, sample_count};
  assign trial      = sq_res + sq_bit;
  assign rms        = sq_res[RMS_W-1:0];
  assign scale_prod = (RMS_W+GAIN_W)'(shifted) * (RMS_W+GAIN_W)'(level_gain);
  assign scale_q    = scale_prod[RMS_W+GAIN_W-1:3];
  assign prev       = hold_ok ? held_level : '0;
  assign decay_prod = (LEVEL_W+DECAY_W)'(prev) * (LEVEL_W+DECAY_W)'(decay_factor);
  assign elapsed    = now_lat - last_speech_time;
  assign in_hold    = elapsed <= TIME_W'(hold_time_ms);
  assign talk       = ptt_lat && in_hold;

  assign sts.in_last   = in_item.last_sample;
  assign sts.in_active = in_item.speech_flag && in_item.ptt_pressed;
  assign sts.div_done  = (div_cnt == DCNT_W'(SUM_W - 1));
  assign sts.sqrt_done = (sq_bit == ROOT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      speech_floor     <= FLOOR_RESET;
      level_gain       <= GAIN_RESET;
      hold_time_ms     <= HOLD_RESET;
      decay_factor     <= DECAY_RESET;
      square_sum       <= '0;
      sample_count     <= '0;
      held_level       <= '0;
      last_speech_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SPEECH_FLOOR: speech_floor <= cfg_data[FLOOR_W-1:0];
          REG_LEVEL_GAIN:   level_gain   <= cfg_data[GAIN_W-1:0];
          REG_HOLD_TIME_MS: hold_time_ms <= cfg_data[HOLD_W-1:0];
          REG_DECAY_FACTOR: decay_factor <= cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && sample_count < CNT_W'(MAX_FRAME_SAMPLES)) begin
        square_sum   <= sum_add;
        sample_count <= sample_count + CNT_W'(1);
      end
      unique case (cmd.op)
        // quotient shifts into the sum register
        OP_DIV: square_sum <= {square_sum[SUM_W-2:0], div_ge};
        OP_UPDATE: begin
          if (level != '0) begin
            held_level       <= (level > decayed) ? level : decayed;
            last_speech_time <= now_lat;
          end
        end
        OP_OUT: begin
          square_sum   <= '0;
          sample_count <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.last_sample) begin
      now_lat <= in_item.now_ms;
      ptt_lat <= in_item.ptt_pressed;
      updated <= 1'b0;
      rem     <= '0;
      div_cnt <= '0;
    end
    unique case (cmd.op)
      OP_DIV: begin
        rem     <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      OP_SQRT_INIT: begin
        sq_x   <= ROOT_W'(square_sum[MEAN_W-1:0]);
        sq_res <= '0;
        sq_bit <= ROOT_W'(1) << 30;
      end
      OP_SQRT: begin
        if (sq_x >= trial) begin
          sq_x   <= sq_x - trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_SUB: shifted <= (rms > RMS_W'(speech_floor)) ? rms - RMS_W'(speech_floor) : '0;
      OP_SCALE: begin
        level   <= (scale_q > LEVEL_MAX) ? LEVEL_MAX : scale_q[LEVEL_W-1:0];
        hold_ok <= in_hold;
      end
      OP_DECAY: decayed <= decay_prod[LEVEL_W+DECAY_W-1:DECAY_W];
      OP_UPDATE: begin
        if (level != '0) begin
          updated <= 1'b1;
        end
      end
      OP_OUT: begin
        out_item.level_out <= talk ? held_level : '0;
        out_item.talking   <= talk;
        out_item.updated   <= updated;
      end
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_held_range, held_level <= LEVEL_MAX)
  `ASSERT_IMPLIES(a_level_range, cmd.op == OP_DECAY, level <= LEVEL_MAX)

endmodule

FILE: hw/rtl/frame_rms_level_meter.sv
// Frame RMS level meter: samples are taken while the controller is idle; a speech frame end
// loads the result register after the bit-serial divider and the 16-step root, then the
// subtract, scale, decay and update states, and the next sample is taken once it is loaded.
// Other frame ends go straight to the finish state that loads it; a stalled result holds both.
// Synchronous active-high reset clears sum, count, held level and time stamp and
// restores the register defaults; no clearing pass. Depends on frlm_pkg, the interfaces,
// frlm_ctrl and frlm_dp.
module frame_rms_level_meter #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  frlm_pkg::cfg_idx_t         cfg_idx,
  input  logic [frlm_pkg::CFG_W-1:0] cfg_data,
  frlm_in_if.sink                    samples,
  frlm_out_if.source                 levels
);
  import frlm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  frlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (levels.valid),
    .out_ready (levels.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  frlm_dp #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_item  (samples.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (levels.data)
  );

endmodule

FILE: tb/frlm_level_checker.sv
// Checker for the frame RMS level meter: watches the sample, result and register ports,
// predicts each frame result and compares it with what the block delivers.
// Depends on frlm_pkg, frlm_in_if and frlm_out_if.
module frlm_level_checker
  import frlm_pkg::*;
#(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [15:0] cfg_data,
  frlm_in_if          samples,
  frlm_out_if         levels,
  output int          errors,
  output int          pending,
  output int          n_samples,
  output int          n_results,
  output int          n_updates,
  output int          n_talking
);

  logic [FLOOR_W-1:0] floor_q15;
  logic [GAIN_W-1:0]  gain;
  logic [HOLD_W-1:0]  hold_ms;
  logic [DECAY_W-1:0] decay_q10;

  longint unsigned    energy_acc;
  int unsigned        frame_len;
  logic [LEVEL_W-1:0] held;
  logic [TIME_W-1:0]  stamp_ms;

  out_item_t expected_levels[$];

  function automatic logic [16:0] int_root(input longint unsigned v);
    logic [16:0] r;
    logic [16:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (longint'(t) * longint'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic bit in_window(input logic [TIME_W-1:0] now_ms);
    logic [TIME_W-1:0] elapsed;
    elapsed = now_ms - stamp_ms;
    return elapsed <= {16'd0, hold_ms};
  endfunction

  function automatic bit predict_frame_level(input in_item_t it, output out_item_t res);
    logic signed [SAMPLE_W-1:0] smp;
    longint                     sq;
    longint unsigned            mean;
    logic [16:0]                rms;
    int unsigned                shifted;
    int unsigned                level;
    int unsigned                prev;
    int unsigned                decayed;
    bit                         upd;
    bit                         talk;
    smp = it.sample;
    upd = 1'b0;
    res = '0;
    if (frame_len < MAX_FRAME_SAMPLES) begin
      sq = longint'(smp) * longint'(smp);
      energy_acc += longint'(sq);
      frame_len++;
    end
    if (!it.last_sample) return 1'b0;

    if (it.speech_flag && it.ptt_pressed && frame_len != 0) begin
      mean = energy_acc / frame_len;
      rms = int_root(mean);
      shifted = (rms > floor_q15) ? rms - floor_q15 : 0;
      level = (shifted * gain) >> 3;
      if (level > LEVEL_MAX) level = LEVEL_MAX;
      if (level != 0) begin
        prev = in_window(it.now_ms) ? held : 0;
        decayed = (prev * decay_q10) >> 10;
        held = (level > decayed) ? level[LEVEL_W-1:0] : decayed[LEVEL_W-1:0];
        stamp_ms = it.now_ms;
        upd = 1'b1;
      end
    end
    energy_acc = 0;
    frame_len = 0;

    talk = it.ptt_pressed && in_window(it.now_ms);
    res.level_out = talk ? held : '0;
    res.talking = talk;
    res.updated = upd;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input out_item_t want, input out_item_t got);
    if (errors < 10) begin
      $display("%s: expected level=%0d talking=%0b updated=%0b, got level=%0d talking=%0b updated=%0b",
               what, want.level_out, want.talking, want.updated,
               got.level_out, got.talking, got.updated);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    out_item_t res;
    if (rst) begin
      floor_q15 = FLOOR_RESET;
      gain = GAIN_RESET;
      hold_ms = HOLD_RESET;
      decay_q10 = DECAY_RESET;
      energy_acc = 0;
      frame_len = 0;
      held = '0;
      stamp_ms = '0;
      expected_levels.delete();
      errors = 0;
      n_samples = 0;
      n_results = 0;
      n_updates = 0;
      n_talking = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SPEECH_FLOOR: floor_q15 = cfg_data[FLOOR_W-1:0];
          REG_LEVEL_GAIN:   gain = cfg_data[GAIN_W-1:0];
          REG_HOLD_TIME_MS: hold_ms = cfg_data[HOLD_W-1:0];
          REG_DECAY_FACTOR: decay_q10 = cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end
      // result first: it can only belong to an earlier sample
      if (levels.valid && levels.ready) begin
        got = levels.data;
        n_results++;
        if (expected_levels.size() == 0) begin
          report_mismatch("result with none outstanding", '0, got);
        end else begin
          want = expected_levels.pop_front();
          if (want.level_out != got.level_out || want.talking != got.talking ||
              want.updated != got.updated) begin
            report_mismatch("level mismatch", want, got);
          end
        end
      end
      if (samples.valid && samples.ready) begin
        n_samples++;
        if (predict_frame_level(samples.data, res)) begin
          expected_levels.push_back(res);
          if (res.updated) n_updates++;
          if (res.talking) n_talking++;
        end
      end
    end
    pending = expected_levels.size();
  end

endmodule

FILE: tb/frame_rms_level_meter_tb.sv
// Top of the frame RMS level meter testbench: clock, reset, register writes, sample
// stimulus with bursty sending and a stalling result side, and the verdict.
// Depends on frlm_pkg, frlm_in_if, frlm_out_if, frlm_level_checker and the block.
module frame_rms_level_meter_tb;
  import frlm_pkg::*;

  localparam int unsigned FRAME_CAP   = 4096;
  localparam int          STALL_LIMIT = 5000;
  localparam int          SETTLE_CYC  = 80;
  localparam int          PHASE_ITEMS = 86;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  logic [15:0] cfg_data;

  frlm_in_if  samples_ch ();
  frlm_out_if levels_ch ();

  int errors;
  int pending;
  int n_samples;
  int n_results;
  int n_updates;
  int n_talking;

  int          burst_left = 0;
  int          hold_cur = HOLD_RESET;
  int          n_settings = 1;
  logic [31:0] wall_ms = '0;
  int          rx_cycle = 0;
  int          rx_mode = 0;
  int          rx_stall = 0;
  int          stuck_cycles = 0;

  frame_rms_level_meter #(
    .MAX_FRAME_SAMPLES(FRAME_CAP)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .samples (samples_ch),
    .levels  (levels_ch)
  );

  frlm_level_checker #(
    .MAX_FRAME_SAMPLES(FRAME_CAP)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .samples  (samples_ch),
    .levels   (levels_ch),
    .errors   (errors),
    .pending  (pending),
    .n_samples(n_samples),
    .n_results(n_results),
    .n_updates(n_updates),
    .n_talking(n_talking)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: always ready, coin toss, or long stalls; the mode is drawn at random
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: levels_ch.ready <= 1'b1;
      1: levels_ch.ready <= ($urandom_range(0, 1) == 1);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          levels_ch.ready <= 1'b0;
        end else begin
          levels_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 40);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) || (levels_ch.valid && levels_ch.ready) ||
        cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
      $display("frame_rms_level_meter test failed");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [15:0] s, input logic last, input logic speech,
                             input logic ptt, input logic [31:0] now);
    in_item_t it;
    int       gap;
    it.sample = s;
    it.last_sample = last;
    it.speech_flag = speech;
    it.ptt_pressed = ptt;
    it.now_ms = now;
    if (burst_left <= 0) begin
      samples_ch.valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.data <= it;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic settle();
    samples_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic configure(input logic [14:0] floor_v, input logic [7:0] gain_v,
                           input logic [15:0] hold_v, input logic [9:0] decay_v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_SPEECH_FLOOR;
    cfg_data <= {1'b0, floor_v};
    @(negedge clk);
    cfg_idx <= REG_LEVEL_GAIN;
    cfg_data <= {8'd0, gain_v};
    @(negedge clk);
    cfg_idx <= REG_HOLD_TIME_MS;
    cfg_data <= hold_v;
    @(negedge clk);
    cfg_idx <= REG_DECAY_FACTOR;
    cfg_data <= {6'd0, decay_v};
    @(negedge clk);
    cfg_we <= 1'b0;
    hold_cur = hold_v;
    n_settings++;
  endtask

  task automatic send_random_frame(inout int count);
    int                  len;
    int                  kind;
    int                  amp;
    int                  r;
    logic signed [15:0]  s;
    logic                speech;
    logic                ptt;
    logic                last;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
    kind = $urandom_range(0, 7);
    amp = (kind < 2) ? $urandom_range(0, 400) : $urandom_range(200, 4000);
    r = $urandom_range(0, 9);
    speech = (r < 7) ? 1'b1 : 1'($urandom_range(0, 1));
    ptt = (r < 7) ? 1'b1 : 1'($urandom_range(0, 1));
    r = $urandom_range(0, 31);
    if (r == 0) wall_ms = $urandom;
    else if (r == 1) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else if (r == 2) wall_ms = wall_ms - $urandom_range(1, 500);
    else wall_ms = wall_ms + $urandom_range(0, hold_cur + hold_cur / 2 + 2);
    for (int i = 0; i < len; i++) begin
      case (kind)
        5:       s = 16'($urandom);
        6:       s = ($urandom_range(0, 1) == 1) ? 16'sh8000 : 16'sh7FFF;
        7:       s = 16'sh8000;
        default: s = 16'($urandom_range(0, 2 * amp) - amp);
      endcase
      last = (i == len - 1);
      send_sample(s, last, last ? speech : 1'($urandom_range(0, 1)),
                  last ? ptt : 1'($urandom_range(0, 1)), last ? wall_ms : $urandom);
    end
    count += len;
  endtask

  initial begin
    int sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_SPEECH_FLOOR;
    cfg_data = '0;
    samples_ch.valid = 1'b0;
    samples_ch.data = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults; time stamp is 0 so push-to-talk alone reads as talking
    send_sample(16'sd0, 1'b1, 1'b0, 1'b1, 32'd0);
    send_sample(16'sh7FFF, 1'b0, 1'b0, 1'b0, 32'd0);
    send_sample(16'sh8000, 1'b0, 1'b0, 1'b0, 32'd0);
    send_sample(16'sd0, 1'b0, 1'b0, 1'b0, 32'd0);
    send_sample(-16'sd1, 1'b1, 1'b1, 1'b1, 32'd100);
    send_sample(16'sd50, 1'b0, 1'b0, 1'b0, 32'd0);
    send_sample(-16'sd50, 1'b1, 1'b1, 1'b1, 32'd150);
    send_sample(16'sd1000, 1'b0, 1'b0, 1'b0, 32'd0);
    send_sample(-16'sd1000, 1'b1, 1'b1, 1'b1, 32'd200);
    send_sample(16'sd20000, 1'b1, 1'b1, 1'b0, 32'd210);
    send_sample(16'sd20000, 1'b1, 1'b0, 1'b1, 32'd220);
    send_sample(16'sd3000, 1'b1, 1'b1, 1'b1, 32'd1000);
    // edge of the hold window, then one past it
    send_sample(16'sd3000, 1'b1, 1'b0, 1'b1, 32'd1240);
    send_sample(16'sd3000, 1'b1, 1'b0, 1'b1, 32'd1241);
    // wrap of the millisecond counter, forwards and backwards
    send_sample(16'sd8000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_sample(16'sd100, 1'b1, 1'b0, 1'b1, 32'h0000_0010);
    send_sample(16'sd100, 1'b1, 1'b0, 1'b1, 32'hFFFF_FF00);
    send_sample(16'sh8000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FF10);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(15'd0, 8'd255, 16'hFFFF, 10'd1023);
        1: configure(15'h7FFF, 8'd255, 16'd0, 10'd0);
        2: configure(15'd200, 8'd0, 16'd100, 10'd512);
        default: configure(15'($urandom_range(0, 600)), 8'($urandom_range(1, 64)),
                           16'($urandom_range(0, 400)), 10'($urandom_range(0, 1023)));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_frame(sent);
      settle();
    end

    $display("covered %0d samples, %0d frame results (%0d level updates, %0d while talking)",
             n_samples, n_results, n_updates, n_talking);
    $display("across %0d register settings including the extremes", n_settings);
    if (errors == 0 && pending == 0) begin
      $display("frame_rms_level_meter test passed");
    end else begin
      $display("frame_rms_level_meter test failed");
    end
    $finish;
  end

endmodule
